/* rtl/core/mdtb_pkg.sv */
// mdtb_pkg: shared types and constants for the decision tree builder
// no dependencies
`default_nettype none
package mdtb_pkg;
  localparam int unsigned StoreDepth = 243;
  localparam int unsigned NodeDepth = 63;

  typedef struct packed {
    logic       is_leaf;
    logic       leaf_value;
    logic [2:0] split_var;
    logic [5:0] child_zero;
    logic [5:0] child_one;
  } node_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_PLAN,
    CMD_TREE_INIT,
    CMD_TREE,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic plan_done;
    logic tree_done;
    logic emit_done;
  } status_t;

  function automatic logic [7:0] pow3(input logic [2:0] k);
    logic [7:0] r;
    unique case (k)
      3'd0: r = 8'd1;
      3'd1: r = 8'd3;
      3'd2: r = 8'd9;
      3'd3: r = 8'd27;
      3'd4: r = 8'd81;
      3'd5: r = 8'd243;
      default: r = 8'd1;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

/* rtl/core/min_decision_tree_builder.sv */
// min_decision_tree_builder: top level joining controller and datapath
// depends on mdtb_pkg, mdtb_ctrl, mdtb_datapath
// One item (num_vars, func_bits) is taken when start is high and busy is low.
// The plan pass visits 3^n partial assignments, then the tree walk pops each node,
// reads its plan entry and writes the node store, then one node is driven per
// cycle with strobe high; last marks the final node.
// The receiver cannot stall, and busy stays high until the last node has been driven.
`default_nettype none
module min_decision_tree_builder import mdtb_pkg::*; #(
  parameter int unsigned MAX_VARS = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  num_vars,
  input  wire logic [31:0] func_bits,
  output logic             strobe,
  output logic [5:0]       node_index,
  output logic             is_leaf,
  output logic             leaf_value,
  output logic [2:0]       split_var,
  output logic [5:0]       child_zero,
  output logic [5:0]       child_one,
  output logic             last
);
  cmd_t    cmd;
  status_t status;
  node_t   node;
  logic    valid;

  mdtb_ctrl u_ctrl (.clk, .rst, .start, .status, .cmd, .busy);
  mdtb_datapath #(.MAX_VARS(MAX_VARS)) u_dp (
    .clk, .cmd, .num_vars, .func_bits, .status, .valid, .node_index, .node, .last
  );

  assign strobe = valid;
  assign is_leaf = node.is_leaf;
  assign leaf_value = node.leaf_value;
  assign split_var = node.split_var;
  assign child_zero = node.child_zero;
  assign child_one = node.child_one;
endmodule
`default_nettype wire

/* rtl/core/mdtb_ctrl.sv */
// mdtb_ctrl: sequencer for load, plan pass, tree walk and node emission
// depends on mdtb_pkg
`default_nettype none
module mdtb_ctrl import mdtb_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy
);
  typedef enum logic [2:0] {S_IDLE, S_PLAN, S_TINIT, S_TREE, S_EMIT} state_t;
  state_t state;

  always_comb begin
    unique case (state)
      S_IDLE:  cmd = (start) ? CMD_LOAD : CMD_NONE;
      S_PLAN:  cmd = CMD_PLAN;
      S_TINIT: cmd = CMD_TREE_INIT;
      S_TREE:  cmd = CMD_TREE;
      S_EMIT:  cmd = CMD_EMIT;
      default: cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin state <= S_PLAN; busy <= 1'b1; end
        S_PLAN: if (status.plan_done) state <= S_TINIT;
        S_TINIT: state <= S_TREE;
        S_TREE: if (status.tree_done) state <= S_EMIT;
        S_EMIT: if (status.emit_done) begin state <= S_IDLE; busy <= 1'b0; end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) == busy) else $error("busy mismatch");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> state == S_PLAN) else $error("no plan after start");
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && status.emit_done) |=> !busy) else $error("busy after emit");
`endif
endmodule
`default_nettype wire

/* rtl/core/mdtb_datapath.sv */
// mdtb_datapath: plan and value-set memories, tree walk stack, node store
// depends on mdtb_pkg
`default_nettype none
module mdtb_datapath import mdtb_pkg::*; #(
  parameter int unsigned MAX_VARS = 5
) (
  input  wire logic        clk,
  input  wire cmd_t        cmd,
  input  wire logic [2:0]  num_vars,
  input  wire logic [31:0] func_bits,
  output status_t          status,
  output logic             valid,
  output logic [5:0]       node_index,
  output node_t            node,
  output logic             last
);
  logic [2:0]  n;
  logic [31:0] tt;
  logic [1:0]  vs_mem [StoreDepth];
  logic [9:0]  plan_mem [StoreDepth];
  node_t       node_mem [NodeDepth];

  // plan pass: per index, phase 0 decode, phases read two entries per var
  logic [7:0]  idx;
  logic [2:0]  dig [5];
  logic [4:0]  assign_bits;
  logic [2:0]  ffree;
  logic        has_free;
  logic [2:0]  ph;
  logic        rd_phase;
  logic [1:0]  vs_a, vs_b;
  logic [9:0]  pl_a, pl_b;
  logic [1:0]  vs_cur;
  logic [5:0]  best_cost;
  logic [2:0]  best_var;
  logic [7:0]  total;
  logic [7:0]  rd0, rd1;

  always_comb begin
    assign_bits = '0;
    has_free = 1'b0;
    ffree = '0;
    for (int k = 4; k >= 0; k--) begin
      if (k < n && dig[k] == 3'd2) begin has_free = 1'b1; ffree = 3'(k); end
      if (k < n && dig[k] == 3'd1) assign_bits[k] = 1'b1;
    end
  end

  // tree walk
  logic [5:0] stk_node [NodeDepth + 1];
  logic [7:0] stk_st [NodeDepth + 1];
  logic [6:0] sp, nxt;
  logic [5:0] cur_nid;
  logic [7:0] cur_st;
  logic [1:0] tph;
  logic [9:0] tplan;
  logic [6:0] ecnt;
  logic [6:0] emit_n;

  logic plan_fin, tree_fin, emit_fin, emit_go;
  assign plan_fin = (cmd == CMD_PLAN) && rd_phase && (ph == 3'd6) && (idx + 8'd1 == total);
  assign tree_fin = (cmd == CMD_TREE) && (tph == 2'd0) && (sp == 7'd0);
  assign emit_go = (cmd == CMD_EMIT) && (ecnt < emit_n);
  assign emit_fin = emit_go && (ecnt + 7'd1 == emit_n);

  always_ff @(posedge clk) begin
    status <= '{plan_done: plan_fin, tree_done: tree_fin, emit_done: emit_fin};
    valid <= emit_go;
    unique case (cmd)
      CMD_LOAD: begin
        n <= (num_vars > 3'(MAX_VARS)) ? 3'(MAX_VARS) : num_vars;
        tt <= func_bits;
        idx <= '0;
        for (int k = 0; k < 5; k++) dig[k] <= '0;
        ph <= '0;
        tph <= 2'd0;
        rd_phase <= 1'b0;
        total <= pow3((num_vars > 3'(MAX_VARS)) ? 3'(MAX_VARS) : num_vars);
      end
      CMD_PLAN: begin
        if (!rd_phase) begin
          if (ph == 3'd0) begin
            rd0 <= idx - (pow3(ffree) << 1);
            rd1 <= idx - pow3(ffree);
            best_cost <= 6'd63;
            best_var <= '0;
            rd_phase <= 1'b1;
          end else begin
            rd0 <= idx - (pow3(ph - 3'd1) << 1);
            rd1 <= idx - pow3(ph - 3'd1);
            rd_phase <= 1'b1;
          end
        end else if (ph == 3'd0) begin
          vs_a <= vs_mem[rd0];
          vs_b <= vs_mem[rd1];
          ph <= 3'd7;
        end else if (ph == 3'd7) begin
          vs_cur <= has_free ? (vs_a | vs_b) : (tt[assign_bits] ? 2'd2 : 2'd1);
          vs_mem[idx] <= has_free ? (vs_a | vs_b) : (tt[assign_bits] ? 2'd2 : 2'd1);
          ph <= 3'd1;
          rd_phase <= 1'b0;
        end else if (ph == 3'd6) begin
          if (vs_cur != 2'd3) plan_mem[idx] <= {8'd0, vs_cur == 2'd2, 1'b1};
          else plan_mem[idx] <= {best_cost[4:0], best_var, 2'b00};
          idx <= idx + 8'd1;
          begin : inc
            logic c;
            c = 1'b1;
            for (int k = 0; k < 5; k++) begin
              if (c) begin
                if (dig[k] == 3'd2) dig[k] <= '0;
                else begin dig[k] <= dig[k] + 3'd1; c = 1'b0; end
              end
            end
          end
          ph <= 3'd0;
          rd_phase <= 1'b0;
        end else begin
          if (tph == 2'd0) begin
            pl_a <= plan_mem[rd0];
            pl_b <= plan_mem[rd1];
            tph <= 2'd1;
          end else begin
            tph <= 2'd0;
            if (vs_cur == 2'd3 && (ph - 3'd1) < n && dig[ph - 3'd1] == 3'd2 &&
                6'd1 + 6'(pl_a[9:5]) + 6'(pl_b[9:5]) < best_cost) begin
              best_cost <= 6'd1 + 6'(pl_a[9:5]) + 6'(pl_b[9:5]);
              best_var <= ph - 3'd1;
            end
            ph <= ph + 3'd1;
            rd_phase <= 1'b0;
          end
        end
      end
      CMD_TREE_INIT: begin
        stk_node[0] <= '0;
        stk_st[0] <= total - 8'd1;
        sp <= 7'd1;
        nxt <= 7'd1;
        tph <= 2'd0;
      end
      CMD_TREE: begin
        unique case (tph)
          2'd0: begin
            if (sp == 7'd0) begin
              emit_n <= (nxt > 7'(NodeDepth)) ? 7'(NodeDepth) : nxt;
              ecnt <= '0;
            end else begin
              cur_nid <= stk_node[6'(sp - 7'd1)];
              cur_st <= stk_st[6'(sp - 7'd1)];
              sp <= sp - 7'd1;
              tph <= 2'd1;
            end
          end
          2'd1: begin
            tplan <= plan_mem[cur_st];
            tph <= 2'd2;
          end
          default: begin
            tph <= 2'd0;
            if (tplan[0]) begin
              node_mem[cur_nid] <= '{1'b1, tplan[1], 3'd0, 6'd0, 6'd0};
            end else begin
              node_mem[cur_nid] <= '{1'b0, 1'b0, tplan[4:2], nxt[5:0], 6'(nxt + 7'd1)};
              nxt <= nxt + 7'd2;
              if (sp + 7'd2 <= 7'(NodeDepth + 1) && nxt + 7'd1 < 7'(NodeDepth)) begin
                stk_node[6'(sp)] <= 6'(nxt + 7'd1);
                stk_st[6'(sp)] <= cur_st - pow3(tplan[4:2]);
                stk_node[6'(sp + 7'd1)] <= nxt[5:0];
                stk_st[6'(sp + 7'd1)] <= cur_st - (pow3(tplan[4:2]) << 1);
                sp <= sp + 7'd2;
              end
            end
          end
        endcase
      end
      CMD_EMIT: begin
        if (emit_go) begin
          node_index <= ecnt[5:0];
          node <= node_mem[ecnt[5:0]];
          last <= (ecnt + 7'd1 == emit_n);
          ecnt <= ecnt + 7'd1;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
